>>> hw/rtl/i2ctbc_pkg.sv
// Package for the I2C target buffer controller.
// Holds item codes, mode and load phase types and the per-word result struct.
// No dependencies.
package i2ctbc_pkg;

  typedef enum logic [3:0] {
    OP_MATCH_WR  = 4'd0,
    OP_MATCH_RD  = 4'd1,
    OP_RX_BYTE   = 4'd2,
    OP_TX_DONE   = 4'd3,
    OP_NACK      = 4'd4,
    OP_STOP      = 4'd5,
    OP_ARB_LOST  = 4'd6,
    OP_HOST_READ = 4'd7,
    OP_HOST_LOAD = 4'd8,
    OP_TICK      = 4'd9
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_RX      = 2'd0,
    MODE_TX      = 2'd1,
    MODE_RX_DONE = 2'd2,
    MODE_TX_DONE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_LOADING   = 2'd1,
    PH_DROP_BUSY = 2'd2,
    PH_DROP_LONG = 2'd3
  } load_phase_t;

  localparam logic [1:0] LD_NONE     = 2'd0;
  localparam logic [1:0] LD_ACCEPTED = 2'd1;
  localparam logic [1:0] LD_BUSY     = 2'd2;
  localparam logic [1:0] LD_TOO_LONG = 2'd3;

  localparam logic [1:0] RCV_NONE   = 2'd0;
  localparam logic [1:0] RCV_STALL  = 2'd1;
  localparam logic [1:0] RCV_BUS    = 2'd2;

  localparam logic [7:0]  FILL_BYTE       = 8'hFF;
  localparam logic [15:0] TIMEOUT_DEFAULT = 16'd100;

  typedef struct packed {
    logic        tx_valid;
    logic        tx_fill;
    logic        host_valid;
    mode_t       mode;
    logic [1:0]  load_status;
    logic        rx_overflow;
    logic        recovered;
    logic [1:0]  recovery_reason;
    logic [7:0]  rx_count;
    logic [8:0]  tx_pending;
  } result_t;

endpackage

>>> hw/rtl/i2ctbc_ctrl.sv
// Transaction state, receive ring and response store of the I2C target buffer controller.
// Updates all state for one accepted word and gives its result; store reads are registered.
// Depends on i2ctbc_pkg.
module i2ctbc_ctrl
  import i2ctbc_pkg::*;
#(
  parameter int RX_DEPTH = 256,
  parameter int TX_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        item_en,
  input  opcode_t     opcode,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        bus_busy,
  output result_t     res,
  output logic [7:0]  rx_rd_byte,
  output logic [7:0]  tx_rd_byte
);

  localparam int RXW  = $clog2(RX_DEPTH);
  localparam int TXCW = $clog2(TX_DEPTH + 1);
  localparam int TXA  = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam logic [RXW-1:0]  RX_LAST = RXW'(RX_DEPTH - 1);
  localparam logic [RXW:0]    RX_SPAN = (RXW + 1)'(RX_DEPTH);
  localparam logic [TXCW-1:0] TX_FULL = TXCW'(TX_DEPTH);

  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];

  logic [15:0]     timeout;
  logic [RXW-1:0]  wr_ptr, wr_ptr_next;
  logic [RXW-1:0]  rd_ptr, rd_ptr_next;
  logic [TXCW-1:0] resp_end, resp_end_next;
  logic [TXCW-1:0] resp_ptr, resp_ptr_next;
  logic [TXCW-1:0] resp_mark, resp_mark_next;
  logic [TXCW-1:0] resp_total, resp_total_next;
  logic [TXCW-1:0] load_count, load_count_next;
  logic [8:0]      started, started_next;
  mode_t           mode_reg, mode_reg_next;
  logic            in_trans, in_trans_next;
  logic            has_resp, has_resp_next;
  logic            tx_armed, tx_armed_next;
  logic            progress, progress_next;
  load_phase_t     phase, phase_next;
  logic [15:0]     idle_ticks, idle_ticks_next;

  logic            rx_we, rx_re, tx_we, tx_re;
  logic [TXCW-1:0] load_cnt;
  logic [TXCW-1:0] avail_next;
  logic [RXW:0]    rx_diff;
  logic [RXW+7:0]  rx_count_ext;
  logic [TXCW+8:0] tx_pend_ext;
  logic [15:0]     limit;
  logic            busy_load;
  logic [RXW-1:0]  wr_ptr_inc;

  always_comb begin
    wr_ptr_next     = wr_ptr;
    rd_ptr_next     = rd_ptr;
    resp_end_next   = resp_end;
    resp_ptr_next   = resp_ptr;
    resp_mark_next  = resp_mark;
    resp_total_next = resp_total;
    load_count_next = load_count;
    started_next    = started;
    mode_reg_next   = mode_reg;
    in_trans_next   = in_trans;
    has_resp_next   = has_resp;
    tx_armed_next   = tx_armed;
    progress_next   = progress;
    phase_next      = phase;
    idle_ticks_next = idle_ticks;
    rx_we           = 1'b0;
    rx_re           = 1'b0;
    tx_we           = 1'b0;
    tx_re           = 1'b0;
    load_cnt        = load_count;
    res             = '0;
    res.tx_fill     = 1'b1;
    limit           = (timeout == 16'd0) ? 16'd1 : timeout;
    busy_load       = (resp_end != resp_ptr) || (mode_reg == MODE_TX);
    wr_ptr_inc      = (wr_ptr == RX_LAST) ? '0 : wr_ptr + 1'b1;

    unique case (opcode)
      OP_MATCH_WR: begin
        in_trans_next = 1'b1;
        progress_next = 1'b1;
        mode_reg_next = MODE_RX;
      end
      OP_MATCH_RD: begin
        in_trans_next   = 1'b1;
        progress_next   = 1'b1;
        mode_reg_next   = MODE_TX;
        has_resp_next   = resp_end != resp_ptr;
        resp_mark_next  = resp_ptr;
        resp_total_next = resp_end - resp_ptr;
        started_next    = 9'd1;
        tx_armed_next   = 1'b1;
        res.tx_valid    = 1'b1;
        if (resp_end != resp_ptr) begin
          tx_re         = 1'b1;
          res.tx_fill   = 1'b0;
          resp_ptr_next = resp_ptr + 1'b1;
        end
      end
      OP_RX_BYTE: begin
        progress_next = 1'b1;
        if (wr_ptr_inc == rd_ptr) begin
          res.rx_overflow = 1'b1;
        end else begin
          rx_we       = 1'b1;
          wr_ptr_next = wr_ptr_inc;
        end
      end
      OP_TX_DONE: begin
        if (tx_armed && mode_reg == MODE_TX) begin
          res.tx_valid  = 1'b1;
          progress_next = 1'b1;
          if (started != 9'd511) begin
            started_next = started + 1'b1;
          end
          if (has_resp && resp_end != resp_ptr) begin
            tx_re         = 1'b1;
            res.tx_fill   = 1'b0;
            resp_ptr_next = resp_ptr + 1'b1;
          end
        end
      end
      OP_NACK: begin
        if (in_trans) begin
          progress_next = 1'b1;
          if (mode_reg == MODE_TX) begin
            tx_armed_next = 1'b0;
          end
        end
      end
      OP_STOP: begin
        if (in_trans) begin
          progress_next = 1'b1;
          tx_armed_next = 1'b0;
          in_trans_next = 1'b0;
          if (mode_reg == MODE_RX) begin
            mode_reg_next = MODE_RX_DONE;
          end else if (mode_reg == MODE_TX) begin
            if (has_resp && ({{TXCW{1'b0}}, started} >= {9'b0, resp_total})) begin
              resp_end_next = '0;
              resp_ptr_next = '0;
              mode_reg_next = MODE_TX_DONE;
            end else begin
              if (has_resp) begin
                resp_ptr_next = resp_mark;
              end
              mode_reg_next = MODE_RX;
            end
            has_resp_next = 1'b0;
          end
        end
      end
      OP_ARB_LOST: begin
        if (in_trans) begin
          progress_next = 1'b1;
          tx_armed_next = 1'b0;
          if (mode_reg == MODE_TX && has_resp) begin
            resp_ptr_next = resp_mark;
          end
        end
      end
      OP_HOST_READ: begin
        if (wr_ptr != rd_ptr) begin
          rx_re          = 1'b1;
          res.host_valid = 1'b1;
          rd_ptr_next    = (rd_ptr == RX_LAST) ? '0 : rd_ptr + 1'b1;
        end
      end
      OP_HOST_LOAD: begin
        if (phase == PH_IDLE && busy_load) begin
          res.load_status = LD_BUSY;
          phase_next      = last_byte ? PH_IDLE : PH_DROP_BUSY;
        end else if (phase == PH_DROP_BUSY || phase == PH_DROP_LONG) begin
          res.load_status = (phase == PH_DROP_BUSY) ? LD_BUSY : LD_TOO_LONG;
          if (last_byte) begin
            phase_next = PH_IDLE;
          end
        end else begin
          load_cnt        = (phase == PH_IDLE) ? '0 : load_count;
          load_count_next = load_cnt;
          phase_next      = PH_LOADING;
          if (load_cnt >= TX_FULL) begin
            res.load_status = LD_TOO_LONG;
            phase_next      = last_byte ? PH_IDLE : PH_DROP_LONG;
          end else if (last_byte && busy_load) begin
            res.load_status = LD_BUSY;
            phase_next      = PH_IDLE;
          end else begin
            tx_we           = 1'b1;
            load_count_next = load_cnt + 1'b1;
            res.load_status = LD_ACCEPTED;
            if (last_byte) begin
              resp_end_next = load_cnt + 1'b1;
              resp_ptr_next = '0;
              if (!in_trans) begin
                mode_reg_next = MODE_RX;
              end
              phase_next = PH_IDLE;
            end
          end
        end
      end
      OP_TICK: begin
        if (progress) begin
          idle_ticks_next = '0;
          progress_next   = 1'b0;
        end else if (idle_ticks != 16'hFFFF) begin
          idle_ticks_next = idle_ticks + 1'b1;
        end
        if (!in_trans && !bus_busy) begin
          idle_ticks_next = '0;
        end else if (idle_ticks_next >= limit) begin
          res.recovered       = 1'b1;
          res.recovery_reason = in_trans ? RCV_STALL : RCV_BUS;
          if (has_resp) begin
            resp_ptr_next = resp_mark;
          end
          wr_ptr_next     = '0;
          rd_ptr_next     = '0;
          mode_reg_next   = MODE_RX;
          in_trans_next   = 1'b0;
          has_resp_next   = 1'b0;
          tx_armed_next   = 1'b0;
          resp_mark_next  = '0;
          resp_total_next = '0;
          started_next    = '0;
          idle_ticks_next = '0;
          progress_next   = 1'b1;
        end
      end
      default: begin
      end
    endcase

    rx_diff = {1'b0, wr_ptr_next} - {1'b0, rd_ptr_next};
    if (wr_ptr_next < rd_ptr_next) begin
      rx_diff = rx_diff + RX_SPAN;
    end
    rx_count_ext   = {8'b0, rx_diff[RXW-1:0]};
    avail_next     = resp_end_next - resp_ptr_next;
    tx_pend_ext    = {9'b0, avail_next};
    res.mode       = mode_reg_next;
    res.rx_count   = rx_count_ext[7:0];
    res.tx_pending = tx_pend_ext[8:0];
  end

  always_ff @(posedge clk) begin
    if (item_en && rx_we) begin
      rx_mem[wr_ptr] <= data_byte;
    end
    if (item_en && rx_re) begin
      rx_rd_byte <= rx_mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (item_en && tx_we) begin
      tx_mem[load_cnt[TXA-1:0]] <= data_byte;
    end
    if (item_en && tx_re) begin
      tx_rd_byte <= tx_mem[resp_ptr[TXA-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout    <= TIMEOUT_DEFAULT;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      resp_end   <= '0;
      resp_ptr   <= '0;
      resp_mark  <= '0;
      resp_total <= '0;
      load_count <= '0;
      started    <= '0;
      mode_reg   <= MODE_RX;
      in_trans   <= 1'b0;
      has_resp   <= 1'b0;
      tx_armed   <= 1'b0;
      progress   <= 1'b1;
      phase      <= PH_IDLE;
      idle_ticks <= '0;
    end else begin
      if (cfg_we) begin
        timeout <= cfg_wdata;
      end
      if (item_en) begin
        wr_ptr     <= wr_ptr_next;
        rd_ptr     <= rd_ptr_next;
        resp_end   <= resp_end_next;
        resp_ptr   <= resp_ptr_next;
        resp_mark  <= resp_mark_next;
        resp_total <= resp_total_next;
        load_count <= load_count_next;
        started    <= started_next;
        mode_reg   <= mode_reg_next;
        in_trans   <= in_trans_next;
        has_resp   <= has_resp_next;
        tx_armed   <= tx_armed_next;
        progress   <= progress_next;
        phase      <= phase_next;
        idle_ticks <= idle_ticks_next;
      end
    end
  end

endmodule

>>> hw/rtl/i2c_target_buffer_controller_unit.sv
// I2C target buffer controller: top level with stream ports and the result pipeline.
// Instantiates i2ctbc_ctrl; depends on i2ctbc_pkg.
//
// Usage: each input word on the s_ group is one bus event or host access; its
// code is in s_tuser, the data byte and bus busy flag in s_tdata, the final
// byte mark of a response load in s_tlast. Every input word gives exactly one
// output word on the m_ group, in order.
// Pipeline: state update, store access and result register s1 load when a word
// is accepted; m_tdata loads from s1 and the store read data when the output
// advances. Throughput is one word per cycle while m_tready allows, set by the
// single ported receive ring and response store, each accessed once per word.
// Reset (rst, synchronous): receive ring empty, response cleared, mode
// receiving, stall timeout back to 100 ticks; store contents are not cleared.
// cfg_we writes the stall timeout in ticks (zero acts as one); write it only
// while no word is in flight.
// When m_tready is low the output word holds and one more word is taken into
// the internal stage; after that s_tready drops until the output drains.
module i2c_target_buffer_controller_unit
  import i2ctbc_pkg::*;
#(
  parameter int RX_DEPTH = 256,
  parameter int TX_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // data_byte[7:0], bus_busy[8], zero[15:9]
  input  logic [3:0]  s_tuser,   // opcode[3:0]
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // tx_byte[7:0], tx_valid[8], host_byte[16:9],
                                 // host_valid[17], mode[19:18], load_status[21:20],
                                 // rx_overflow[22], recovered[23],
                                 // recovery_reason[25:24], rx_count[33:26],
                                 // tx_pending[42:34], zero[47:43]
);

  logic       accept;
  logic       advance;
  result_t    res;
  logic [7:0] rx_rd_byte;
  logic [7:0] tx_rd_byte;
  logic       s1_valid;
  result_t    s1;
  logic [7:0] tx_byte;
  logic [7:0] host_byte;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;

  i2ctbc_ctrl #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_en    (accept),
    .opcode     (opcode_t'(s_tuser)),
    .data_byte  (s_tdata[7:0]),
    .last_byte  (s_tlast),
    .bus_busy   (s_tdata[8]),
    .res        (res),
    .rx_rd_byte (rx_rd_byte),
    .tx_rd_byte (tx_rd_byte)
  );

  always_comb begin
    if (!s1.tx_valid) begin
      tx_byte = 8'h00;
    end else if (s1.tx_fill) begin
      tx_byte = FILL_BYTE;
    end else begin
      tx_byte = tx_rd_byte;
    end
    host_byte = s1.host_valid ? rx_rd_byte : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= res;
    end
    if (advance && s1_valid) begin
      m_tdata <= {5'b0, s1.tx_pending, s1.rx_count, s1.recovery_reason, s1.recovered,
                  s1.rx_overflow, s1.load_status, s1.mode, s1.host_valid, host_byte,
                  s1.tx_valid, tx_byte};
    end
  end

`ifndef ASSERT_OFF
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && m_tvalid))
    else $error("input stalled while the pipeline has room");

  a_recover_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1.recovered) |-> (s1.mode == MODE_RX && s1.rx_count == 8'd0))
    else $error("recovery left receive side active");

  a_load_not_tx: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1.load_status == LD_ACCEPTED) |-> (s1.mode != MODE_TX))
    else $error("response byte accepted during a read");

  a_one_source: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !(s1.tx_valid && s1.host_valid))
    else $error("bus and host byte in the same word");
`endif

endmodule
